### rtl/rdcl_pkg.sv
// ----------------------------------------------------------------------------
// rdcl_pkg: shared types and constants of the radio duty cycle limiter
// Holds the word kinds, the field widths and the reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
package rdcl_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned AirW    = 16;
  localparam int unsigned MinIntW = 22;
  localparam int unsigned WindowW = 27;
  localparam int unsigned DutyW   = 17;
  localparam int unsigned CfgIdxW = 1;

  // The numerator of the duty division is a window-sized airtime times DutyFull.
  localparam int unsigned NumW    = WindowW + DutyW;
  // One quotient bit per divider step.
  localparam int unsigned DivSteps = DutyW;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);

  localparam logic [DutyW-1:0]   DutyFull        = DutyW'(100000);
  localparam logic [MinIntW-1:0] MinIntervalRst  = MinIntW'(60000);
  localparam logic [WindowW-1:0] WindowRst       = WindowW'(3600000);

  typedef enum logic [KindW-1:0] {
    KindQuery   = 2'd0,
    KindDone    = 2'd1,
    KindRestart = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinInterval = 1'b0,
    CfgWindow      = 1'b1
  } cfg_idx_e;

endpackage

### rtl/rdcl_if.sv
// ----------------------------------------------------------------------------
// rdcl_if: handshake channels of the radio duty cycle limiter
// One interface for the event words coming in and one for the result words.
// ----------------------------------------------------------------------------
interface rdcl_in_if;
  logic                       valid;
  logic                       ready;
  logic [rdcl_pkg::KindW-1:0] kind;
  logic [rdcl_pkg::TimeW-1:0] now_ms;
  logic [rdcl_pkg::AirW-1:0]  airtime_ms;

  modport source (output valid, kind, now_ms, airtime_ms, input ready);
  modport sink   (input valid, kind, now_ms, airtime_ms, output ready);
endinterface

interface rdcl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [rdcl_pkg::MinIntW-1:0] wait_ms;
  logic [rdcl_pkg::DutyW-1:0]   duty_milli_percent;

  modport source (output valid, allowed, wait_ms, duty_milli_percent, input ready);
  modport sink   (input valid, allowed, wait_ms, duty_milli_percent, output ready);
endinterface

### rtl/rdcl_div.sv
// ----------------------------------------------------------------------------
// rdcl_div: iterative restoring divider for the duty figure
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits in DutyW bits, i.e. num < den * 2**DutyW.
// ----------------------------------------------------------------------------
module rdcl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rdcl_pkg::NumW-1:0]    num_i,
  input  logic [rdcl_pkg::WindowW-1:0] den_i,
  output logic                         done_o,
  output logic [rdcl_pkg::DutyW-1:0]   quo_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [rdcl_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [rdcl_pkg::WindowW-1:0] rem_q, rem_d;
  logic [rdcl_pkg::WindowW-1:0] den_q, den_d;
  logic [rdcl_pkg::DutyW-1:0]   low_q, low_d;
  logic [rdcl_pkg::DutyW-1:0]   quo_q, quo_d;
  logic [rdcl_pkg::WindowW:0]   trial;
  logic [rdcl_pkg::WindowW:0]   diff;
  logic                         fits;

  assign trial = {rem_q, low_q[rdcl_pkg::DutyW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rdcl_pkg::CntW'(rdcl_pkg::DivSteps);
      rem_d  = num_i[rdcl_pkg::NumW-1:rdcl_pkg::DutyW];
      low_d  = num_i[rdcl_pkg::DutyW-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[rdcl_pkg::WindowW-1:0] : trial[rdcl_pkg::WindowW-1:0];
      low_d = {low_q[rdcl_pkg::DutyW-2:0], 1'b0};
      quo_d = {quo_q[rdcl_pkg::DutyW-2:0], fits};
      cnt_d = cnt_q - rdcl_pkg::CntW'(1);
      if (cnt_q == rdcl_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/radio_duty_cycle_limiter.sv
// ----------------------------------------------------------------------------
// radio_duty_cycle_limiter: transmit gate with an airtime accounting window
// Tracks the last send time and the airtime spent in the current window and
// answers every event word with the remaining wait and the duty figure.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word contents
//  in_i     sink       kind, now_ms, airtime_ms
//  out_o    source     allowed, wait_ms, duty_milli_percent
//  cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i (no read-back)
//
// An event word passes through the sequencer steps from acceptance to the result
// register; the divider resolves one quotient bit per cycle and is the longest
// step. Words whose duty is zero or saturated skip the division.
// in_i is ready only while the sequencer is idle. A stalled result sits in the
// output register while the next word is accepted and worked on; the sequencer
// waits at its last step only if that register is still full.
// Reset is asynchronous and clears the sequencer, the accounting state and the
// configuration registers to their defaults.
module radio_duty_cycle_limiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rdcl_in_if.sink                      in_i,
  rdcl_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [rdcl_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rdcl_pkg::WindowW-1:0] cfg_data_i
);

  // Sequencer steps, one per cycle except the division and a stalled push.
  typedef enum logic [3:0] {
    StIdle,
    StRoll,
    StAccum,
    StWait,
    StSpan,
    StSat,
    StMul,
    StGo,
    StDiv,
    StPush
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [rdcl_pkg::MinIntW-1:0] min_int_q, min_int_d;
  logic [rdcl_pkg::WindowW-1:0] window_q, window_d;

  // Accounting state.
  logic [rdcl_pkg::TimeW-1:0]   last_send_q, last_send_d;
  logic                         ever_sent_q, ever_sent_d;
  logic [rdcl_pkg::TimeW-1:0]   total_q, total_d;
  logic [rdcl_pkg::TimeW-1:0]   win_start_q, win_start_d;

  // The word being worked on and intermediate results.
  logic [rdcl_pkg::KindW-1:0]   kind_q, kind_d;
  logic [rdcl_pkg::TimeW-1:0]   now_q, now_d;
  logic [rdcl_pkg::AirW-1:0]    air_q, air_d;
  logic [rdcl_pkg::MinIntW-1:0] wait_q, wait_d;
  logic [rdcl_pkg::WindowW-1:0] span_q, span_d;
  logic [rdcl_pkg::NumW-1:0]    prod_q, prod_d;
  logic [rdcl_pkg::DutyW-1:0]   duty_q, duty_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [rdcl_pkg::MinIntW-1:0] out_wait_q, out_wait_d;
  logic [rdcl_pkg::DutyW-1:0]   out_duty_q, out_duty_d;

  logic                         div_start;
  logic                         div_done;
  logic [rdcl_pkg::DutyW-1:0]   div_quo;

  logic [rdcl_pkg::TimeW-1:0]   since_start;
  logic [rdcl_pkg::TimeW-1:0]   since_send;
  logic [rdcl_pkg::TimeW:0]     air_sum;
  logic                         is_done;

  // Elapsed times wrap modulo 2**32 like the time base itself.
  assign since_start = now_q - win_start_q;
  assign since_send  = now_q - last_send_q;
  assign air_sum     = {1'b0, total_q} + {{(rdcl_pkg::TimeW + 1 - rdcl_pkg::AirW){1'b0}}, air_q};
  assign is_done     = kind_q == rdcl_pkg::KindDone;

  rdcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (span_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    min_int_d   = min_int_q;
    window_d    = window_q;
    last_send_d = last_send_q;
    ever_sent_d = ever_sent_q;
    total_d     = total_q;
    win_start_d = win_start_q;
    kind_d      = kind_q;
    now_d       = now_q;
    air_d       = air_q;
    wait_d      = wait_q;
    span_d      = span_q;
    prod_d      = prod_q;
    duty_d      = duty_q;
    out_wait_d  = out_wait_q;
    out_duty_d  = out_duty_q;
    out_valid_d = out_valid_q && !out_o.ready;
    div_start   = 1'b0;

    // The user must write configuration only while no word is in flight; unchecked.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdcl_pkg::CfgMinInterval: min_int_d = cfg_data_i[rdcl_pkg::MinIntW-1:0];
        rdcl_pkg::CfgWindow:      window_d  = cfg_data_i;
        default:                  ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          kind_d  = in_i.kind;
          now_d   = in_i.now_ms;
          air_d   = in_i.airtime_ms;
          state_d = StRoll;
        end
      end
      // A restart opens a new window; a completion does so only once the
      // current window has run out.
      StRoll: begin
        if (kind_q == rdcl_pkg::KindRestart) begin
          total_d     = '0;
          ever_sent_d = 1'b0;
          win_start_d = now_q;
        end else if (is_done &&
                     since_start >= {{(rdcl_pkg::TimeW - rdcl_pkg::WindowW){1'b0}}, window_q}) begin
          total_d     = '0;
          win_start_d = now_q;
        end
        state_d = StAccum;
      end
      // Airtime accumulates with saturation at the top of the 32-bit range.
      StAccum: begin
        if (is_done) begin
          total_d     = air_sum[rdcl_pkg::TimeW] ? '1 : air_sum[rdcl_pkg::TimeW-1:0];
          last_send_d = now_q;
          ever_sent_d = 1'b1;
        end
        state_d = StWait;
      end
      StWait: begin
        if (!ever_sent_q ||
            since_send >= {{(rdcl_pkg::TimeW - rdcl_pkg::MinIntW){1'b0}}, min_int_q}) begin
          wait_d = '0;
        end else begin
          wait_d = min_int_q - since_send[rdcl_pkg::MinIntW-1:0];
        end
        state_d = StSpan;
      end
      StSpan: begin
        if (since_start > {{(rdcl_pkg::TimeW - rdcl_pkg::WindowW){1'b0}}, window_q}) begin
          span_d = window_q;
        end else begin
          span_d = since_start[rdcl_pkg::WindowW-1:0];
        end
        state_d = StSat;
      end
      // A zero span gives zero duty; otherwise airtime at or above the span is at
      // least full scale, so only a smaller airtime needs the division.
      StSat: begin
        if (span_q == '0) begin
          duty_d  = '0;
          state_d = StPush;
        end else if (total_q >= {{(rdcl_pkg::TimeW - rdcl_pkg::WindowW){1'b0}}, span_q}) begin
          duty_d  = rdcl_pkg::DutyFull;
          state_d = StPush;
        end else begin
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = total_q[rdcl_pkg::WindowW-1:0] * rdcl_pkg::DutyFull;
        state_d = StGo;
      end
      StGo: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          duty_d  = div_quo;
          state_d = StPush;
        end
      end
      StPush: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_wait_d  = wait_q;
          out_duty_d  = duty_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      min_int_q   <= rdcl_pkg::MinIntervalRst;
      window_q    <= rdcl_pkg::WindowRst;
      last_send_q <= '0;
      ever_sent_q <= 1'b0;
      total_q     <= '0;
      win_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_int_q   <= min_int_d;
      window_q    <= window_d;
      last_send_q <= last_send_d;
      ever_sent_q <= ever_sent_d;
      total_q     <= total_d;
      win_start_q <= win_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    now_q      <= now_d;
    air_q      <= air_d;
    wait_q     <= wait_d;
    span_q     <= span_d;
    prod_q     <= prod_d;
    duty_q     <= duty_d;
    out_wait_q <= out_wait_d;
    out_duty_q <= out_duty_d;
  end

  assign in_i.ready               = state_q == StIdle;
  assign out_o.valid              = out_valid_q;
  assign out_o.allowed            = out_wait_q == '0;
  assign out_o.wait_ms            = out_wait_q;
  assign out_o.duty_milli_percent = out_duty_q;

  // An accepted word keeps the input closed until its result is registered.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted a second word while one was in flight");

  // The duty figure never exceeds full scale.
  a_duty_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.duty_milli_percent <= rdcl_pkg::DutyFull)
    else $error("duty figure above full scale");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside the division step");

  // A registered result holds while the sink stalls.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.wait_ms) &&
      $stable(out_o.duty_milli_percent))
    else $error("stalled result word changed");

endmodule

### bench/radio_duty_cycle_limiter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radio_duty_cycle_limiter_test: self-checking bench of the transmit gate
// Feeds event words through the input channel, predicts every result word
// from a local copy of the gate state and compares it field by field with
// what the output channel delivers, across several register settings.
// ----------------------------------------------------------------------------
module radio_duty_cycle_limiter_test;

  // Kind code 3 has no member in the package; the gate treats it as a query.
  localparam logic [rdcl_pkg::KindW-1:0] KindUnknown = 2'd3;
  // Drain allowance after the last result, a bit above the slowest word.
  localparam int unsigned SettleCycles = 40;
  // Receiver hold-off long enough to fill the gate and stall its input.
  localparam int unsigned LongHold = 400;
  // A correct run finishes within this limit even with the longest gaps.
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned PrintCap = 100;

  typedef struct packed {
    logic [rdcl_pkg::KindW-1:0] kind;
    logic [rdcl_pkg::TimeW-1:0] now_ms;
    logic [rdcl_pkg::AirW-1:0]  airtime_ms;
  } event_word_t;

  typedef struct packed {
    logic                         allowed;
    logic [rdcl_pkg::MinIntW-1:0] wait_ms;
    logic [rdcl_pkg::DutyW-1:0]   duty;
  } gate_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [rdcl_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [rdcl_pkg::WindowW-1:0] cfg_data_i;

  rdcl_in_if  in_ch ();
  rdcl_out_if out_ch ();

  radio_duty_cycle_limiter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Words waiting to be offered, and the results the gate owes us, oldest first.
  event_word_t  pending_words[$];
  gate_result_t expected_results[$];

  // Local copy of the gate: its registers and its accounting state.
  logic [rdcl_pkg::MinIntW-1:0] lim_min_interval;
  logic [rdcl_pkg::WindowW-1:0] lim_window;
  logic [rdcl_pkg::TimeW-1:0]   last_send_ms;
  logic                         sent_since_restart;
  logic [31:0]                  airtime_sum;
  logic [rdcl_pkg::TimeW-1:0]   window_begin_ms;

  // Rough mirror of the timeline used only to aim random words at boundaries.
  logic [rdcl_pkg::TimeW-1:0] gen_clock_ms;
  logic [rdcl_pkg::TimeW-1:0] gen_window_ms;
  logic [rdcl_pkg::TimeW-1:0] gen_last_ms;

  bit          idling_on;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;

  // Applies one word to the local state and returns the result it must give.
  // The result is always taken after the state update.
  function automatic gate_result_t predict_gate(input event_word_t w);
    logic [31:0] elapsed;
    logic [31:0] span;
    logic [31:0] wait_left;
    logic [63:0] quotient;
    gate_result_t r;
    if (w.kind == rdcl_pkg::KindRestart) begin
      airtime_sum        = '0;
      sent_since_restart = 1'b0;
      window_begin_ms    = w.now_ms;
    end else if (w.kind == rdcl_pkg::KindDone) begin
      // A completion first rolls the window over once it has run its length.
      elapsed = w.now_ms - window_begin_ms;
      if (elapsed >= 32'(lim_window)) begin
        airtime_sum     = '0;
        window_begin_ms = w.now_ms;
      end
      // The airtime sum sticks at all ones instead of wrapping.
      if (airtime_sum > 32'hFFFF_FFFF - 32'(w.airtime_ms)) airtime_sum = 32'hFFFF_FFFF;
      else airtime_sum = airtime_sum + 32'(w.airtime_ms);
      last_send_ms       = w.now_ms;
      sent_since_restart = 1'b1;
    end

    // Nothing sent since reset or restart means no wait at all.
    wait_left = '0;
    if (sent_since_restart) begin
      elapsed = w.now_ms - last_send_ms;
      if (elapsed < 32'(lim_min_interval)) wait_left = 32'(lim_min_interval) - elapsed;
    end
    r.allowed = (wait_left == 0);
    r.wait_ms = wait_left[rdcl_pkg::MinIntW-1:0];

    // The duty is taken over the elapsed part of the window, capped at its length.
    span = w.now_ms - window_begin_ms;
    if (span > 32'(lim_window)) span = 32'(lim_window);
    if (span == 0) begin
      r.duty = '0;
    end else begin
      quotient = ({32'b0, airtime_sum} * 64'(rdcl_pkg::DutyFull)) / {32'b0, span};
      r.duty = (quotient > 64'(rdcl_pkg::DutyFull)) ? rdcl_pkg::DutyFull :
                                                       quotient[rdcl_pkg::DutyW-1:0];
    end
    return r;
  endfunction

  // Gap before the next word or the next accepted result. Most gaps are short
  // and a few are long; with idling off there are none.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (!idling_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  // Input driver. A word stays on the channel until the gate takes it; the
  // prediction is made at the very edge where it is accepted, so the local
  // state follows the gate's order of words exactly.
  event_word_t current_word;
  int unsigned send_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_gate(current_word));
        send_gap = draw_gap();
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Still offered, the gate is busy.
      end else if (send_gap != 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        current_word = pending_words.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= current_word.kind;
        in_ch.now_ms     <= current_word.now_ms;
        in_ch.airtime_ms <= current_word.airtime_ms;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output monitor. Every accepted result is checked against the oldest
  // prediction. Ready drops for a random stretch after some results, and for
  // one long stretch whenever the stimulus asks for a hold-off.
  gate_result_t want;
  int unsigned  stall_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.allowed !== want.allowed)
            report_mismatch("allowed", out_ch.allowed, want.allowed);
          if (out_ch.wait_ms !== want.wait_ms)
            report_mismatch("wait_ms", out_ch.wait_ms, want.wait_ms);
          if (out_ch.duty_milli_percent !== want.duty)
            report_mismatch("duty_milli_percent", out_ch.duty_milli_percent, want.duty);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left = LongHold;
      end else if (stall_left == 0 && out_ch.valid && out_ch.ready) begin
        stall_left = draw_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung gate ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("radio_duty_cycle_limiter_test failed");
      $finish;
    end
  end

  task automatic push_word(input logic [rdcl_pkg::KindW-1:0] kind,
                           input logic [rdcl_pkg::TimeW-1:0] now_ms,
                           input logic [rdcl_pkg::AirW-1:0] airtime_ms);
    event_word_t w;
    w.kind       = kind;
    w.now_ms     = now_ms;
    w.airtime_ms = airtime_ms;
    pending_words.push_back(w);
  endtask

  // Registers are only written while the gate is idle, so the local copy can
  // follow the write at once.
  task automatic write_register(input rdcl_pkg::cfg_idx_e idx,
                                input logic [rdcl_pkg::WindowW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == rdcl_pkg::CfgMinInterval) lim_min_interval = value[rdcl_pkg::MinIntW-1:0];
    else lim_window = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every word is taken and every result has come back, then
  // lets the gate settle.
  task automatic drain_results();
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Random words. Most follow a plausible timeline that moves forward by steps
  // on the scale of the interval or the window, some land right on the
  // interval or window boundary, and a few jump anywhere in time.
  task automatic push_random_words(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    logic [rdcl_pkg::TimeW-1:0] now_ms;
    logic [rdcl_pkg::KindW-1:0] kind;
    logic [rdcl_pkg::AirW-1:0]  air;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) gen_clock_ms += $urandom_range(0, 2 * lim_min_interval + 2);
      else if (roll < 65) gen_clock_ms += $urandom_range(0, 20);
      else if (roll < 80) gen_clock_ms += $urandom_range(0, lim_window + lim_window / 4 + 2);
      else if (roll < 87) gen_clock_ms = gen_last_ms + lim_min_interval - $urandom_range(0, 1);
      else if (roll < 94) gen_clock_ms = gen_window_ms + lim_window - $urandom_range(0, 1);
      now_ms = (roll >= 94) ? $urandom() : gen_clock_ms;

      roll = $urandom_range(0, 99);
      if (roll < 50) kind = rdcl_pkg::KindQuery;
      else if (roll < 80) kind = rdcl_pkg::KindDone;
      else if (roll < 90) kind = rdcl_pkg::KindRestart;
      else kind = KindUnknown;

      roll = $urandom_range(0, 9);
      if (roll < 6) air = rdcl_pkg::AirW'($urandom_range(0, 2000));
      else if (roll < 9) air = rdcl_pkg::AirW'($urandom());
      else air = $urandom_range(0, 1) ? '1 : '0;

      if (kind == rdcl_pkg::KindRestart) begin
        gen_window_ms = now_ms;
      end else if (kind == rdcl_pkg::KindDone) begin
        if (now_ms - gen_window_ms >= lim_window) gen_window_ms = now_ms;
        gen_last_ms = now_ms;
      end
      push_word(kind, now_ms, air);
    end
  endtask

  // One register setting with about a hundred random words. With a hold-off
  // the first half is offered back to back while the receiver stalls.
  task automatic run_setting(input logic [rdcl_pkg::MinIntW-1:0] min_interval,
                             input logic [rdcl_pkg::WindowW-1:0] window, input bit with_hold);
    write_register(rdcl_pkg::CfgMinInterval, rdcl_pkg::WindowW'(min_interval));
    write_register(rdcl_pkg::CfgWindow, window);
    gen_clock_ms  = window_begin_ms + $urandom_range(0, 100);
    gen_window_ms = window_begin_ms;
    gen_last_ms   = last_send_ms;
    idling_on = with_hold ? 1'b0 : 1'($urandom_range(0, 1));
    push_random_words(50);
    if (with_hold) hold_requests++;
    while (pending_words.size() > 4) @(negedge clk_i);
    idling_on = !idling_on;
    push_random_words(50);
    drain_results();
  endtask

  logic [rdcl_pkg::TimeW-1:0] base_ms;
  int unsigned                k;

  initial begin
    cfg_we_i   = 1'b0;
    cfg_idx_i  = rdcl_pkg::CfgMinInterval;
    cfg_data_i = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = rdcl_pkg::KindQuery;
    in_ch.now_ms     = '0;
    in_ch.airtime_ms = '0;
    out_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    lim_min_interval   = rdcl_pkg::MinIntervalRst;
    lim_window         = rdcl_pkg::WindowRst;
    last_send_ms       = '0;
    sent_since_restart = 1'b0;
    airtime_sum        = '0;
    window_begin_ms    = '0;
    idling_on     = 1'b1;
    hold_requests = 0;
    hold_served   = 0;
    mismatches    = 0;
    results_seen  = 0;
    cycle_count   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at the reset setting: 60 s interval, one hour window.
    // Queries from a fresh gate, at time zero and at the top of the range.
    push_word(rdcl_pkg::KindQuery, 32'h0000_0000, 16'h0000);
    push_word(rdcl_pkg::KindQuery, 32'hFFFF_FFFF, 16'h0000);
    // The unknown kind answers like a query and leaves the state alone.
    push_word(KindUnknown, 32'd1234, 16'hFFFF);
    // Completions: the result waits the full interval.
    push_word(rdcl_pkg::KindDone, 32'd1000, 16'h0000);
    push_word(rdcl_pkg::KindDone, 32'd1800, 16'd18);
    // One millisecond short of the interval, then exactly on it.
    push_word(rdcl_pkg::KindQuery, 32'd61799, 16'h0000);
    push_word(rdcl_pkg::KindQuery, 32'd61800, 16'h0000);
    // A completion exactly one window after the start rolls the window over.
    push_word(rdcl_pkg::KindDone, 32'd3600000, 16'd36000);
    // Half duty, exactly full duty, just over full duty, and a small figure.
    push_word(rdcl_pkg::KindQuery, 32'd3672000, 16'h0000);
    push_word(rdcl_pkg::KindQuery, 32'd3636000, 16'h0000);
    push_word(rdcl_pkg::KindQuery, 32'd3635999, 16'h0000);
    push_word(rdcl_pkg::KindQuery, 32'd7199999, 16'h0000);
    // Restart shortly before the time wraps: the last send time is kept but
    // no longer counts, so the wait is zero.
    push_word(rdcl_pkg::KindRestart, 32'hFFFF_FF00, 16'hFFFF);
    push_word(rdcl_pkg::KindQuery, 32'hFFFF_FF00, 16'h0000);
    // Largest airtime, then a query across the wrap of the time.
    push_word(rdcl_pkg::KindDone, 32'hFFFF_FFF0, 16'hFFFF);
    push_word(rdcl_pkg::KindQuery, 32'h0000_0010, 16'h0000);
    push_word(rdcl_pkg::KindDone, 32'h0000_0100, 16'hFFFF);
    push_word(KindUnknown, 32'h0002_0000, 16'h0000);
    drain_results();

    // A zero window restarts on every completion and reads zero duty.
    write_register(rdcl_pkg::CfgMinInterval, rdcl_pkg::WindowW'(1000));
    write_register(rdcl_pkg::CfgWindow, '0);
    push_word(rdcl_pkg::KindDone, 32'd500, 16'd7);
    push_word(rdcl_pkg::KindQuery, 32'd900, 16'h0000);
    push_word(rdcl_pkg::KindDone, 32'd900, 16'd9);
    push_word(rdcl_pkg::KindQuery, 32'd1900, 16'h0000);
    drain_results();

    // Random words across settings, the extremes among them.
    run_setting(rdcl_pkg::MinIntervalRst, rdcl_pkg::WindowRst, 1'b0);
    run_setting(22'd0, 27'd1, 1'b0);
    run_setting(22'd3600000, 27'd86400000, 1'b1);
    run_setting('1, '1, 1'b0);
    run_setting(22'd1000, 27'd0, 1'b0);
    run_setting(rdcl_pkg::MinIntW'($urandom_range(100, 5000)),
                rdcl_pkg::WindowW'($urandom_range(2000, 50000)), 1'b1);

    // The longest window: a few of the largest airtimes at one instant, which
    // keeps the span at zero, then queries around the point where the span
    // reaches the window length.
    write_register(rdcl_pkg::CfgMinInterval, rdcl_pkg::WindowW'(3600000));
    write_register(rdcl_pkg::CfgWindow, '1);
    idling_on = 1'b0;
    base_ms = $urandom();
    push_word(rdcl_pkg::KindRestart, base_ms, 16'h0000);
    for (k = 0; k < 4; k++) begin
      push_word(rdcl_pkg::KindDone, base_ms, 16'hFFFF);
    end
    push_word(rdcl_pkg::KindQuery, base_ms + 32'd100, 16'h0000);
    push_word(rdcl_pkg::KindQuery, base_ms + 32'h07FF_FFFE, 16'h0000);
    push_word(rdcl_pkg::KindQuery, base_ms + 32'h07FF_FFFF, 16'h0000);
    push_word(rdcl_pkg::KindQuery, base_ms + 32'h0800_0000, 16'h0000);
    // The window has run its length, so this completion starts it afresh.
    push_word(rdcl_pkg::KindDone, base_ms + 32'h07FF_FFFF, 16'd5);
    push_word(rdcl_pkg::KindQuery, base_ms + 32'h07FF_FFFF + 32'd1000, 16'h0000);
    drain_results();

    if (mismatches == 0) begin
      $display("radio_duty_cycle_limiter_test passed");
    end else begin
      $display("radio_duty_cycle_limiter_test failed");
    end
    $finish;
  end

endmodule
